// ----- rtl/core/c2d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and constants
// Request codes, register indexes, sequencer states and default sizes
// for the dilated, strided 2D convolution core.
// ----------------------------------------------------------------------------
package c2d_pkg;

    localparam int DEF_MAX_IN_CH  = 16;
    localparam int DEF_MAX_OUT_CH = 16;
    localparam int DEF_MAX_KERNEL = 8;
    localparam int DEF_FRAME_ROWS = 64;
    localparam int DEF_FRAME_COLS = 64;

    localparam int DATA_W   = 16;
    localparam int BIAS_W   = 32;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 48;
    localparam int CFG_W    = 5;
    localparam int CFG_IX_W = 3;
    localparam int POS_W    = 12;   // padded coordinate incl. window overshoot
    localparam int NC_W     = 7;    // clamped channel count, up to 64
    localparam int NK_W     = 5;    // clamped kernel size, up to 16

    typedef enum logic [1:0] {
        REQ_LOAD_WEIGHT = 2'd0,
        REQ_LOAD_BIAS   = 2'd1,
        REQ_WRITE_SMP   = 2'd2,
        REQ_COMPUTE     = 2'd3
    } req_t;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_IN_CHANNELS = 3'd0,
        CFG_KERNEL_H    = 3'd1,
        CFG_KERNEL_W    = 3'd2,
        CFG_STRIDE_H    = 3'd3,
        CFG_STRIDE_W    = 3'd4,
        CFG_DILATION_H  = 3'd5,
        CFG_DILATION_W  = 3'd6,
        CFG_BIAS_ENABLE = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // one tap issued to the memories, tracked alongside the read data
    typedef struct packed {
        logic valid;
        logic oob;
    } tap_t;

    function automatic int aw(input int n);
        return (n <= 1) ? 1 : $clog2(n);
    endfunction

endpackage

// ----- rtl/core/conv2d_dilated_strided_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_dilated_strided_core: 2D convolution, stride, dilation, bias
// Weight, bias and padded frame stores in single-port RAMs; one MAC walks
// the window tap by tap for each compute request.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   transfer when
//  -------   ---------------------------------------   ------------------------
//  request   start, busy, req_type .. bias_word        start & !busy at clk
//  result    result_valid, result_value, status        result_valid (one cycle)
//  config    cfg_we, cfg_index, cfg_data               cfg_we at clk
//
//  Loads and sample writes strobe their result in the next cycle, and a
//  new request may be taken at once.
//  A compute over channels*kernel_h*kernel_w taps (each count clamped to
//  the store sizes) holds busy while it issues one tap per cycle through the
//  weight and frame RAM ports, then drains the read, multiply and accumulate
//  stages; its result strobes in the same cycle as busy drops.
//  An empty window issues no taps and goes straight to the drain.
//  After reset the frame RAM is zeroed one entry per cycle, all 2^(bits of
//  channel+row+col) = 65536 entries at default sizes; busy is high meanwhile.
//  The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module conv2d_dilated_strided_core #(
    parameter int MAX_IN_CH  = c2d_pkg::DEF_MAX_IN_CH,
    parameter int MAX_OUT_CH = c2d_pkg::DEF_MAX_OUT_CH,
    parameter int MAX_KERNEL = c2d_pkg::DEF_MAX_KERNEL,
    parameter int FRAME_ROWS = c2d_pkg::DEF_FRAME_ROWS,
    parameter int FRAME_COLS = c2d_pkg::DEF_FRAME_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic [3:0]                          out_channel,
    input  logic [3:0]                          in_channel,
    input  logic [5:0]                          row,
    input  logic [5:0]                          col,
    input  logic [2:0]                          kernel_row,
    input  logic [2:0]                          kernel_col,
    input  logic signed [15:0]                  data_value,
    input  logic signed [31:0]                  bias_word,
    output logic                                result_valid,
    output logic signed [47:0]                  result_value,
    output logic                                status,
    input  logic                                cfg_we,
    input  logic [c2d_pkg::CFG_IX_W-1:0]        cfg_index,
    input  logic [c2d_pkg::CFG_W-1:0]           cfg_data
);

    localparam int OCW = c2d_pkg::aw(MAX_OUT_CH);
    localparam int ICW = c2d_pkg::aw(MAX_IN_CH);
    localparam int KW  = c2d_pkg::aw(MAX_KERNEL);
    localparam int RW  = c2d_pkg::aw(FRAME_ROWS);
    localparam int CLW = c2d_pkg::aw(FRAME_COLS);
    localparam int WAW = OCW + ICW + 2 * KW;
    localparam int FAW = ICW + RW + CLW;
    localparam int PW  = c2d_pkg::POS_W;
    localparam int NCW = c2d_pkg::NC_W;
    localparam int NKW = c2d_pkg::NK_W;

    // configuration registers
    logic [4:0] chan_count_reg;
    logic [3:0] kernel_h_reg, kernel_w_reg, stride_h_reg, stride_w_reg;
    logic [3:0] dilation_h_reg, dilation_w_reg;
    logic       bias_enable_reg;

    c2d_pkg::state_t state_reg, state_next;

    logic [FAW-1:0] clr_reg, clr_next;
    logic [OCW-1:0] oc_reg, oc_next;
    logic [PW-1:0]  h0_reg, h0_next, w0_reg, w0_next;
    logic [PW-1:0]  r_reg, r_next, q_reg, q_next;
    logic [ICW-1:0] c_reg, c_next;
    logic [KW-1:0]  i_reg, i_next, j_reg, j_next;

    logic                       result_valid_reg, result_valid_next;
    logic signed [47:0]         result_value_reg, result_value_next;
    logic                       status_reg, status_next;

    logic           accept;
    c2d_pkg::req_t  req;
    logic           wt_ok, bias_ok, smp_ok, oc_ok;
    logic [NCW-1:0] nc;
    logic [NKW-1:0] nh, nw;
    logic           empty, last_j, last_i, last_c;
    logic [PW-1:0]  h0_calc, w0_calc;

    // memory ports
    logic                   w_we, b_we, f_we;
    logic [WAW-1:0]         w_addr;
    logic [OCW-1:0]         b_addr;
    logic [FAW-1:0]         f_addr;
    logic [15:0]            f_wdata;
    logic signed [15:0]     w_rdata, f_rdata;
    logic signed [31:0]     b_rdata;

    c2d_pkg::tap_t          issue;
    logic                   mac_clear;
    logic signed [47:0]     acc;
    logic                   acc_oob, pipe_busy;

    assign req     = c2d_pkg::req_t'(req_type);
    assign accept  = start && !busy;
    assign wt_ok   = (32'(out_channel) < MAX_OUT_CH) && (32'(in_channel) < MAX_IN_CH)
                   && (32'(kernel_row) < MAX_KERNEL) && (32'(kernel_col) < MAX_KERNEL);
    assign bias_ok = 32'(out_channel) < MAX_OUT_CH;
    assign smp_ok  = (32'(in_channel) < MAX_IN_CH) && (32'(row) < FRAME_ROWS)
                   && (32'(col) < FRAME_COLS);
    assign oc_ok   = 32'(out_channel) < MAX_OUT_CH;

    // clamp oversized counts to what the stores hold
    assign nc = (32'(chan_count_reg) > MAX_IN_CH) ? NCW'(MAX_IN_CH) : NCW'(chan_count_reg);
    assign nh = (32'(kernel_h_reg) > MAX_KERNEL) ? NKW'(MAX_KERNEL) : NKW'(kernel_h_reg);
    assign nw = (32'(kernel_w_reg) > MAX_KERNEL) ? NKW'(MAX_KERNEL) : NKW'(kernel_w_reg);
    assign empty  = (nc == '0) || (nh == '0) || (nw == '0);
    assign last_j = NKW'(j_reg) == (nw - NKW'(1));
    assign last_i = NKW'(i_reg) == (nh - NKW'(1));
    assign last_c = NCW'(c_reg) == (nc - NCW'(1));

    assign h0_calc = PW'(row) * PW'(stride_h_reg);
    assign w0_calc = PW'(col) * PW'(stride_w_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg  <= 5'd1;
            kernel_h_reg    <= 4'd3;
            kernel_w_reg    <= 4'd3;
            stride_h_reg    <= 4'd1;
            stride_w_reg    <= 4'd1;
            dilation_h_reg  <= 4'd1;
            dilation_w_reg  <= 4'd1;
            bias_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (c2d_pkg::cfg_idx_t'(cfg_index))
                c2d_pkg::CFG_IN_CHANNELS: chan_count_reg  <= cfg_data;
                c2d_pkg::CFG_KERNEL_H:    kernel_h_reg    <= cfg_data[3:0];
                c2d_pkg::CFG_KERNEL_W:    kernel_w_reg    <= cfg_data[3:0];
                c2d_pkg::CFG_STRIDE_H:    stride_h_reg    <= cfg_data[3:0];
                c2d_pkg::CFG_STRIDE_W:    stride_w_reg    <= cfg_data[3:0];
                c2d_pkg::CFG_DILATION_H:  dilation_h_reg  <= cfg_data[3:0];
                c2d_pkg::CFG_DILATION_W:  dilation_w_reg  <= cfg_data[3:0];
                c2d_pkg::CFG_BIAS_ENABLE: bias_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            c2d_pkg::ST_CLEAR:
            begin
                if (&clr_reg)
                begin
                    state_next = c2d_pkg::ST_IDLE;
                end
            end
            c2d_pkg::ST_IDLE:
            begin
                if (accept && req == c2d_pkg::REQ_COMPUTE && oc_ok)
                begin
                    state_next = c2d_pkg::ST_RUN;
                end
            end
            c2d_pkg::ST_RUN:
            begin
                if (empty || (last_j && last_i && last_c))
                begin
                    state_next = c2d_pkg::ST_DRAIN;
                end
            end
            c2d_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = c2d_pkg::ST_IDLE;
                end
            end
            default: state_next = c2d_pkg::ST_CLEAR;
        endcase
    end

    // outputs of the sequencer: memory ports, tap issue, busy
    always_comb
    begin
        busy      = (state_reg != c2d_pkg::ST_IDLE);
        w_we      = 1'b0;
        b_we      = 1'b0;
        f_we      = 1'b0;
        w_addr    = {OCW'(out_channel), ICW'(in_channel), KW'(kernel_row), KW'(kernel_col)};
        b_addr    = oc_reg;
        f_addr    = {ICW'(in_channel), RW'(row), CLW'(col)};
        f_wdata   = data_value;
        issue     = '0;
        mac_clear = 1'b0;
        unique case (state_reg)
            c2d_pkg::ST_CLEAR:
            begin
                f_we    = 1'b1;
                f_addr  = clr_reg;
                f_wdata = '0;
            end
            c2d_pkg::ST_IDLE:
            begin
                b_addr    = OCW'(out_channel);
                w_we      = accept && req == c2d_pkg::REQ_LOAD_WEIGHT && wt_ok;
                b_we      = accept && req == c2d_pkg::REQ_LOAD_BIAS && bias_ok;
                f_we      = accept && req == c2d_pkg::REQ_WRITE_SMP && smp_ok;
                mac_clear = accept && req == c2d_pkg::REQ_COMPUTE;
            end
            c2d_pkg::ST_RUN:
            begin
                w_addr      = {oc_reg, c_reg, i_reg, j_reg};
                f_addr      = {c_reg, RW'(r_reg), CLW'(q_reg)};
                issue.valid = !empty;
                issue.oob   = (32'(r_reg) >= FRAME_ROWS) || (32'(q_reg) >= FRAME_COLS);
            end
            c2d_pkg::ST_DRAIN: ;
            default: ;
        endcase
    end

    // window counters and result
    always_comb
    begin
        clr_next          = clr_reg;
        oc_next           = oc_reg;
        h0_next           = h0_reg;
        w0_next           = w0_reg;
        r_next            = r_reg;
        q_next            = q_reg;
        c_next            = c_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        result_valid_next = 1'b0;
        result_value_next = '0;
        status_next       = c2d_pkg::STATUS_OK;

        case (state_reg)
            c2d_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + FAW'(1);
            end
            c2d_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    oc_next = OCW'(out_channel);
                    h0_next = h0_calc;
                    w0_next = w0_calc;
                    r_next  = h0_calc;
                    q_next  = w0_calc;
                    c_next  = '0;
                    i_next  = '0;
                    j_next  = '0;
                    case (req)
                        c2d_pkg::REQ_LOAD_WEIGHT:
                        begin
                            result_valid_next = 1'b1;
                            status_next       = wt_ok ? c2d_pkg::STATUS_OK : c2d_pkg::STATUS_ERR;
                        end
                        c2d_pkg::REQ_LOAD_BIAS:
                        begin
                            result_valid_next = 1'b1;
                            status_next = bias_ok ? c2d_pkg::STATUS_OK : c2d_pkg::STATUS_ERR;
                        end
                        c2d_pkg::REQ_WRITE_SMP:
                        begin
                            result_valid_next = 1'b1;
                            status_next = smp_ok ? c2d_pkg::STATUS_OK : c2d_pkg::STATUS_ERR;
                        end
                        default:
                        begin
                            // compute on a missing output channel answers at once
                            result_valid_next = !oc_ok;
                            status_next = oc_ok ? c2d_pkg::STATUS_OK : c2d_pkg::STATUS_ERR;
                        end
                    endcase
                end
            end
            c2d_pkg::ST_RUN:
            begin
                // advance column, then row, then channel
                if (!empty)
                begin
                    if (!last_j)
                    begin
                        j_next = j_reg + KW'(1);
                        q_next = q_reg + PW'(dilation_w_reg);
                    end
                    else
                    begin
                        j_next = '0;
                        q_next = w0_reg;
                        if (!last_i)
                        begin
                            i_next = i_reg + KW'(1);
                            r_next = r_reg + PW'(dilation_h_reg);
                        end
                        else
                        begin
                            i_next = '0;
                            r_next = h0_reg;
                            c_next = c_reg + ICW'(1);
                        end
                    end
                end
            end
            c2d_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    result_valid_next = 1'b1;
                    result_value_next = bias_enable_reg ? acc + 48'(b_rdata) : acc;
                    status_next = acc_oob ? c2d_pkg::STATUS_ERR : c2d_pkg::STATUS_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= c2d_pkg::ST_CLEAR;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        oc_reg           <= oc_next;
        h0_reg           <= h0_next;
        w0_reg           <= w0_next;
        r_reg            <= r_next;
        q_reg            <= q_next;
        c_reg            <= c_next;
        i_reg            <= i_next;
        j_reg            <= j_next;
        result_value_reg <= result_value_next;
        status_reg       <= status_next;
    end

    assign result_valid = result_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

    c2d_ram #(
        .WIDTH (c2d_pkg::DATA_W),
        .DEPTH (1 << WAW)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .addr  (w_addr),
        .wdata (data_value),
        .rdata (w_rdata)
    );

    c2d_ram #(
        .WIDTH (c2d_pkg::BIAS_W),
        .DEPTH (1 << OCW)
    ) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .addr  (b_addr),
        .wdata (bias_word),
        .rdata (b_rdata)
    );

    c2d_ram #(
        .WIDTH (c2d_pkg::DATA_W),
        .DEPTH (1 << FAW)
    ) u_frame_ram (
        .clk   (clk),
        .we    (f_we),
        .addr  (f_addr),
        .wdata (f_wdata),
        .rdata (f_rdata)
    );

    c2d_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (mac_clear),
        .issue     (issue),
        .wdata     (w_rdata),
        .sdata     (f_rdata),
        .acc       (acc),
        .oob       (acc_oob),
        .pipe_busy (pipe_busy)
    );

endmodule

// ----- rtl/core/c2d_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_ram: generic single-port RAM
// One access per cycle at one address, a write also reading the old word; read data registered.
// ----------------------------------------------------------------------------
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [c2d_pkg::aw(DEPTH)-1:0]  addr,
    input  logic [WIDTH-1:0]               wdata,
    output logic [WIDTH-1:0]               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/c2d_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_mac: tap multiply-accumulate pipeline
// Registers the product of weight and sample, then accumulates into 48 bits.
// ----------------------------------------------------------------------------
module c2d_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  c2d_pkg::tap_t                       issue,
    input  logic signed [c2d_pkg::DATA_W-1:0]   wdata,
    input  logic signed [c2d_pkg::DATA_W-1:0]   sdata,
    output logic signed [c2d_pkg::ACC_W-1:0]    acc,
    output logic                                oob,
    output logic                                pipe_busy
);

    c2d_pkg::tap_t                      s1_reg;
    logic                               pv_reg;
    logic signed [c2d_pkg::PROD_W-1:0]  prod_reg;
    logic signed [c2d_pkg::ACC_W-1:0]   acc_reg;
    logic                               oob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            pv_reg  <= 1'b0;
            acc_reg <= '0;
            oob_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= issue;
            pv_reg <= s1_reg.valid;
            if (clear)
            begin
                acc_reg <= '0;
                oob_reg <= 1'b0;
            end
            else
            begin
                if (pv_reg)
                begin
                    acc_reg <= acc_reg + c2d_pkg::ACC_W'(prod_reg);
                end
                if (s1_reg.valid && s1_reg.oob)
                begin
                    oob_reg <= 1'b1;
                end
            end
        end
    end

    // drop taps outside the store: they add zero
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid && !s1_reg.oob)
        begin
            prod_reg <= wdata * sdata;
        end
        else
        begin
            prod_reg <= '0;
        end
    end

    assign acc       = acc_reg;
    assign oob       = oob_reg;
    assign pipe_busy = s1_reg.valid | pv_reg;

endmodule

// ----- rtl/core/c2d_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_checker: port-level checks for the convolution core
// Watches request and result ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module c2d_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic [1:0]                       req_type,
    input logic                             result_valid,
    input logic signed [47:0]               result_value
);

    logic simple_req;
    assign simple_req = start && !busy && (req_type != c2d_pkg::REQ_COMPUTE);

    // a load or sample write answers on the next cycle
    a_simple_answers: assert property (@(posedge clk) disable iff (!rst_n)
        simple_req |=> result_valid)
        else $error("load or write gave no result on the next cycle");

    // loads and writes report a zero value
    a_simple_zero: assert property (@(posedge clk) disable iff (!rst_n)
        simple_req |=> (result_value == 48'sd0))
        else $error("load or write result is not zero");

    // a compute either answers at once or holds busy
    a_compute_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == c2d_pkg::REQ_COMPUTE) |=> (busy || result_valid))
        else $error("compute dropped without busy or result");

    // a result while busy can only finish a compute: busy drops with it
    a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(busy) && !$past(start && !busy)) |-> !busy)
        else $error("compute result shown while still busy");

endmodule

bind conv2d_dilated_strided_core c2d_checker u_c2d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .result_valid (result_valid),
    .result_value (result_value)
);

// ----- tb/sv/conv2d_dilated_strided_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_dilated_strided_checker: result predictor and scoreboard
// Watches the request, result and register channels of the convolution core.
// Keeps its own weight, bias and frame stores and register copies, predicts
// every result, and compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module conv2d_dilated_strided_checker
    import c2d_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [1:0]          req_type,
    input  logic [3:0]          out_channel,
    input  logic [3:0]          in_channel,
    input  logic [5:0]          row,
    input  logic [5:0]          col,
    input  logic [2:0]          kernel_row,
    input  logic [2:0]          kernel_col,
    input  logic signed [15:0]  data_value,
    input  logic signed [31:0]  bias_word,
    input  logic                result_valid,
    input  logic signed [47:0]  result_value,
    input  logic                status,
    input  logic                cfg_we,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output int                  failures,
    output int                  outstanding
);

    localparam int NIC = DEF_MAX_IN_CH;
    localparam int NOC = DEF_MAX_OUT_CH;
    localparam int NK  = DEF_MAX_KERNEL;
    localparam int FR  = DEF_FRAME_ROWS;
    localparam int FC  = DEF_FRAME_COLS;

    typedef struct {
        logic signed [47:0] value;
        logic               err;
    } conv_result_t;

    logic signed [15:0] weights [NOC*NIC*NK*NK];
    logic signed [31:0] biases  [NOC];
    logic signed [15:0] frame   [NIC*FR*FC];

    logic [4:0] r_in_ch;
    logic [3:0] r_kh, r_kw, r_sh, r_sw, r_dh, r_dw;
    logic       r_bias_en;

    conv_result_t awaited_results[$];

    initial begin
        failures    = 0;
        outstanding = 0;
        foreach (frame[i]) frame[i] = '0;
        foreach (biases[i]) biases[i] = '0;
        foreach (weights[i]) weights[i] = '0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] conv mismatch: %s", $realtime, what);
        failures++;
    endtask

    // apply one transfer to the stores and work out its result
    function automatic conv_result_t convolve_request();
        conv_result_t res;
        longint acc;
        int nc, nh, nw, r, q;
        res.err = STATUS_OK;
        acc     = 0;
        case (req_t'(req_type))
            REQ_LOAD_WEIGHT:
                weights[((out_channel*NIC + in_channel)*NK + kernel_row)*NK + kernel_col]
                    = data_value;
            REQ_LOAD_BIAS:
                biases[out_channel] = bias_word;
            REQ_WRITE_SMP:
                frame[(in_channel*FR + row)*FC + col] = data_value;
            default: begin
                nc = (r_in_ch > NIC) ? NIC : r_in_ch;
                nh = (r_kh > NK) ? NK : r_kh;
                nw = (r_kw > NK) ? NK : r_kw;
                for (int c = 0; c < nc; c++)
                    for (int i = 0; i < nh; i++)
                        for (int j = 0; j < nw; j++) begin
                            r = row*r_sh + i*r_dh;
                            q = col*r_sw + j*r_dw;
                            // taps past the store read as zero, flag the window
                            if (r >= FR || q >= FC)
                                res.err = STATUS_ERR;
                            else
                                acc += longint'(weights[((out_channel*NIC + c)*NK + i)*NK + j])
                                     * longint'(frame[(c*FR + r)*FC + q]);
                        end
                if (r_bias_en)
                    acc += longint'(biases[out_channel]);
            end
        endcase
        res.value = acc[47:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        conv_result_t got_exp;
        if (!rst_n) begin
            r_in_ch   <= 5'd1;
            r_kh      <= 4'd3;
            r_kw      <= 4'd3;
            r_sh      <= 4'd1;
            r_sw      <= 4'd1;
            r_dh      <= 4'd1;
            r_dw      <= 4'd1;
            r_bias_en <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_IN_CHANNELS: r_in_ch   <= cfg_data[4:0];
                    CFG_KERNEL_H:    r_kh      <= cfg_data[3:0];
                    CFG_KERNEL_W:    r_kw      <= cfg_data[3:0];
                    CFG_STRIDE_H:    r_sh      <= cfg_data[3:0];
                    CFG_STRIDE_W:    r_sw      <= cfg_data[3:0];
                    CFG_DILATION_H:  r_dh      <= cfg_data[3:0];
                    CFG_DILATION_W:  r_dw      <= cfg_data[3:0];
                    default:         r_bias_en <= cfg_data[0];
                endcase
            end
            if (result_valid) begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with nothing awaited");
                else begin
                    got_exp = awaited_results.pop_front();
                    if (result_value !== got_exp.value)
                        report_mismatch($sformatf("value %0d, want %0d",
                                                  result_value, got_exp.value));
                    if (status !== got_exp.err)
                        report_mismatch($sformatf("status %0b, want %0b",
                                                  status, got_exp.err));
                end
            end
            if (start && !busy)
                awaited_results.push_back(convolve_request());
            outstanding = awaited_results.size();
        end
    end

endmodule

// ----- tb/sv/conv2d_dilated_strided_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_dilated_strided_core_tb: stimulus and verdict for the conv core
// Runs a directed set at reset sizes, then random weight, bias, sample and
// compute transfers over several register settings, extremes included.
// The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module conv2d_dilated_strided_core_tb;
    import c2d_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 20;
    localparam int NPHASE      = 7;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          req_type;
    logic [3:0]          out_channel;
    logic [3:0]          in_channel;
    logic [5:0]          row;
    logic [5:0]          col;
    logic [2:0]          kernel_row;
    logic [2:0]          kernel_col;
    logic signed [15:0]  data_value;
    logic signed [31:0]  bias_word;
    logic                result_valid;
    logic signed [47:0]  result_value;
    logic                status;
    logic                cfg_we;
    logic [CFG_IX_W-1:0] cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    int  failures;
    int  outstanding;
    int  cycles;
    bit  idling_on;

    // which weight and bias slots hold a value; computes never read others
    bit  weight_loaded [DEF_MAX_OUT_CH*DEF_MAX_IN_CH*DEF_MAX_KERNEL*DEF_MAX_KERNEL];
    bit  bias_loaded   [DEF_MAX_OUT_CH];
    int  cur_regs [8];

    // register settings per phase, in register index order
    int phase_regs [NPHASE][8] = '{
        '{ 1,  1,  1,  1,  1,  1,  1, 0},
        '{ 2,  3,  3,  2,  2,  1,  1, 1},
        '{16,  8,  1,  8,  8,  8,  8, 1},
        '{31, 15,  1, 15, 15, 15, 15, 0},
        '{ 0,  0,  0,  0,  0,  0,  0, 1},
        '{ 1,  3, 15,  1,  1,  2,  2, 1},
        '{ 3,  2,  5,  0,  3,  1,  0, 0}
    };
    int phase_items [NPHASE] = '{90, 100, 30, 25, 70, 50, 80};

    conv2d_dilated_strided_core dut (.*);

    conv2d_dilated_strided_checker scoreboard (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop if the core hangs
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // offer one request and hold it until the core takes it
    task automatic transfer(input req_t kind, input logic [3:0] oc, input logic [3:0] ic,
                            input logic [5:0] r, input logic [5:0] c,
                            input logic [2:0] kr, input logic [2:0] kc,
                            input logic [15:0] dv, input logic [31:0] bv);
        int gap;
        // now and then, while idling is on, insert a random gap before the request
        if (idling_on && $urandom_range(99) < 20) begin
            gap = $urandom_range(4, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= kind;
        out_channel <= oc;
        in_channel  <= ic;
        row         <= r;
        col         <= c;
        kernel_row  <= kr;
        kernel_col  <= kc;
        data_value  <= dv;
        bias_word   <= bv;
        do @(posedge clk); while (busy);
        if (kind == REQ_LOAD_WEIGHT)
            weight_loaded[((oc*DEF_MAX_IN_CH + ic)*DEF_MAX_KERNEL + kr)*DEF_MAX_KERNEL + kc] = 1;
        if (kind == REQ_LOAD_BIAS)
            bias_loaded[oc] = 1;
    endtask

    // a request with every field random, kind and key fields overridden
    task automatic random_transfer(input req_t kind, input logic [3:0] oc,
                                   input logic [3:0] ic, input logic [5:0] r,
                                   input logic [5:0] c, input logic [2:0] kr,
                                   input logic [2:0] kc);
        transfer(kind, oc, ic, r, c, kr, kc, 16'($urandom), $urandom);
    endtask

    // load whatever weights and bias a compute on this channel would read
    task automatic fill_channel(input logic [3:0] oc);
        int nc, nh, nw;
        nc = (cur_regs[CFG_IN_CHANNELS] > DEF_MAX_IN_CH) ? DEF_MAX_IN_CH
                                                         : cur_regs[CFG_IN_CHANNELS];
        nh = (cur_regs[CFG_KERNEL_H] > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL
                                                       : cur_regs[CFG_KERNEL_H];
        nw = (cur_regs[CFG_KERNEL_W] > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL
                                                       : cur_regs[CFG_KERNEL_W];
        if (!bias_loaded[oc])
            random_transfer(REQ_LOAD_BIAS, oc, 4'($urandom), 6'($urandom), 6'($urandom),
                            3'($urandom), 3'($urandom));
        for (int ch = 0; ch < nc; ch++)
            for (int i = 0; i < nh; i++)
                for (int j = 0; j < nw; j++)
                    if (!weight_loaded[((oc*DEF_MAX_IN_CH + ch)*DEF_MAX_KERNEL + i)
                                       *DEF_MAX_KERNEL + j])
                        random_transfer(REQ_LOAD_WEIGHT, oc, 4'(ch), 6'($urandom),
                                        6'($urandom), 3'(i), 3'(j));
    endtask

    task automatic compute_at(input logic [3:0] oc, input logic [5:0] r, input logic [5:0] c);
        fill_channel(oc);
        random_transfer(REQ_COMPUTE, oc, 4'($urandom), r, c, 3'($urandom), 3'($urandom));
    endtask

    // hold off until every awaited result is in
    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_regs(input int p);
        for (int k = 0; k < 8; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IX_W'(k);
            cfg_data  <= CFG_W'(phase_regs[p][k]);
            cur_regs[k] = phase_regs[p][k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly small coordinates so computes land on written samples
    function automatic logic [5:0] near_coord(input int hi);
        return ($urandom_range(99) < 75) ? 6'($urandom_range(hi)) : 6'($urandom);
    endfunction

    task automatic random_phase(input int p, input int n_items);
        int pick;
        logic [3:0] oc;
        bit heavy;
        heavy = (phase_regs[p][0] * phase_regs[p][1] * phase_regs[p][2] > 32);
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            // computes use output channels 0, 5, 10 and 15 only
            oc   = heavy ? 4'd0 : 4'(5 * $urandom_range(3));
            if (pick < 20)
                random_transfer(REQ_LOAD_WEIGHT, 4'($urandom), 4'($urandom), 6'($urandom),
                                6'($urandom), 3'($urandom), 3'($urandom));
            else if (pick < 30)
                random_transfer(REQ_LOAD_BIAS, 4'($urandom), 4'($urandom), 6'($urandom),
                                6'($urandom), 3'($urandom), 3'($urandom));
            else if (pick < 62)
                random_transfer(REQ_WRITE_SMP, 4'($urandom), 4'($urandom), near_coord(20),
                                near_coord(20), 3'($urandom), 3'($urandom));
            else
                compute_at(oc, near_coord(8), near_coord(8));
            // once per phase, let the pipeline run dry mid-stream
            if (n == n_items / 2)
                wait_quiet();
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_LOAD_WEIGHT;
        out_channel = '0;
        in_channel  = '0;
        row         = '0;
        col         = '0;
        kernel_row  = '0;
        kernel_col  = '0;
        data_value  = '0;
        bias_word   = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_IN_CHANNELS;
        cfg_data    = '0;
        cycles      = 0;
        idling_on   = 1'b1;
        cur_regs    = '{1, 3, 3, 1, 1, 1, 1, 0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes at reset sizes; busy covers the frame clear
        transfer(REQ_WRITE_SMP, 4'd0, 4'd0, 6'd0, 6'd0, 3'd0, 3'd0, 16'h7FFF, '0);
        transfer(REQ_WRITE_SMP, 4'd15, 4'd15, 6'd63, 6'd63, 3'd7, 3'd7, 16'h8000, '1);
        transfer(REQ_WRITE_SMP, 4'd0, 4'd0, 6'd1, 6'd2, 3'd0, 3'd0, 16'h8000, '0);
        transfer(REQ_WRITE_SMP, 4'd0, 4'd0, 6'd2, 6'd2, 3'd0, 3'd0, 16'hFFFF, '0);
        transfer(REQ_LOAD_BIAS, 4'd0, 4'd0, '0, '0, '0, '0, '0, 32'h7FFF_FFFF);
        transfer(REQ_LOAD_BIAS, 4'd15, 4'd15, '1, '1, '1, '1, '1, 32'h8000_0000);
        transfer(REQ_LOAD_WEIGHT, 4'd15, 4'd15, 6'd63, 6'd63, 3'd7, 3'd7, 16'h7FFF, '1);
        transfer(REQ_LOAD_WEIGHT, 4'd0, 4'd0, '0, '0, 3'd0, 3'd0, 16'h8000, '0);
        transfer(REQ_LOAD_WEIGHT, 4'd0, 4'd0, '0, '0, 3'd1, 3'd2, 16'h7FFF, '0);
        transfer(REQ_LOAD_WEIGHT, 4'd0, 4'd0, '0, '0, 3'd2, 3'd2, 16'h8000, '0);
        compute_at(4'd0, 6'd0, 6'd0);
        compute_at(4'd0, 6'd61, 6'd61);
        compute_at(4'd0, 6'd62, 6'd0);
        compute_at(4'd15, 6'd63, 6'd63);
        compute_at(4'd15, 6'd0, 6'd63);

        // random phases over register settings
        for (int p = 0; p < NPHASE; p++) begin
            wait_quiet();
            write_regs(p);
            idling_on = (p != 1);
            random_phase(p, phase_items[p]);
        end
        idling_on = 1'b1;

        // drain, then give the core time for a stray strobe
        wait_quiet();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
